[design/bres_pkg.sv]
// ----------------------------------------------------------------------------
// bres_pkg
// Shared constants for the Bresenham line pixel generator.
// ----------------------------------------------------------------------------
package bres_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COLOR_BITS     = 32;

   // request word modes
   localparam logic MODE_START = 1'b0;

endpackage

[design/bres_if.sv]
// ----------------------------------------------------------------------------
// bres_req_if / bres_rsp_if
// Valid/ready channels carrying line requests and pixel responses.
// ----------------------------------------------------------------------------
interface bres_req_if
   import bres_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF) ();

   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [COORD_BITS-1:0]  start_x;
   logic signed [COORD_BITS-1:0]  start_y;
   logic signed [COORD_BITS-1:0]  end_x;
   logic signed [COORD_BITS-1:0]  end_y;
   logic        [COLOR_BITS-1:0]  line_color;

   modport source (output valid, mode, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, mode, start_x, start_y, end_x, end_y, line_color,
                   output ready);

endinterface

interface bres_rsp_if
   import bres_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF) ();

   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  pixel_x;
   logic signed [COORD_BITS-1:0]  pixel_y;
   logic        [COLOR_BITS-1:0]  pixel_color;
   logic                          last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   output ready);

endinterface

[design/bresenham_line_pixel_generator.sv]
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// Integer Bresenham line stepper: a start word sets up a line and emits its
// first pixel, each tick word emits the next pixel until the far endpoint.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    mode, start_x/y, end_x/y, line_color
//   rsp_chan   out   valid/ready    pixel_x/y, pixel_color, last_pixel
//
// One word per cycle unless the response stalls; setup, then pixel register.
// Setup stage: endpoint deltas, steepness and ordering into a register.
// Step stage: one error subtract/compare, position update per unstalled cycle.
// A stalled response holds the step stage; the setup register still takes a
// word if empty. Reset clears the line-active flag and both valid flags.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator
   import bres_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF)
   (
      input  logic            clock,
      input  logic            reset,
      bres_req_if.sink        req_chan,
      bres_rsp_if.source      rsp_chan
   );

   localparam int CB = COORD_BITS;

   // setup stage
   logic signed [CB:0]    dx, dy;
   logic        [CB:0]    adx_w, ady_w;
   logic        [CB-1:0]  adx, ady;
   logic                  steep, swap_ends;
   logic signed [CB-1:0]  maj0, min0, maj1, min1;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_start_ff;
   logic                  s1_steep_ff;
   logic signed [CB-1:0]  s1_major_ff, s1_minor_ff, s1_major_end_ff, s1_minor_end_ff;
   logic        [CB-1:0]  s1_dmaj_ff, s1_dmin_ff;
   logic [COLOR_BITS-1:0] s1_color_ff;

   // line state
   logic                  line_active_ff, line_active_in;
   logic                  steep_ff;
   logic signed [CB-1:0]  major_pos_ff, minor_pos_ff, major_end_ff, minor_end_ff;
   logic        [CB-1:0]  delta_major_ff, delta_minor_ff;
   logic signed [CB:0]    error_term_ff;
   logic [COLOR_BITS-1:0] held_color_ff;

   // step stage
   logic                  cur_steep;
   logic signed [CB-1:0]  cur_major, cur_minor, cur_major_end, cur_minor_end;
   logic        [CB-1:0]  cur_dmaj, cur_dmin;
   logic signed [CB:0]    cur_err, err_sub, err_in;
   logic [COLOR_BITS-1:0] cur_color;
   logic signed [CB-1:0]  minor_step, minor_in, major_in;
   logic                  is_last, produce, step_go, req_go;

   logic                  out_valid_ff, out_valid_in;
   logic signed [CB-1:0]  pixel_x_ff, pixel_y_ff;
   logic [COLOR_BITS-1:0] pixel_color_ff;
   logic                  last_pixel_ff;

   // ---------------- setup ----------------
   assign dx = {req_chan.end_x[CB-1], req_chan.end_x}
             - {req_chan.start_x[CB-1], req_chan.start_x};
   assign dy = {req_chan.end_y[CB-1], req_chan.end_y}
             - {req_chan.start_y[CB-1], req_chan.start_y};
   assign adx_w = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
   assign ady_w = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
   assign adx   = adx_w[CB-1:0];
   assign ady   = ady_w[CB-1:0];
   assign steep = (adx < ady);
   assign swap_ends = steep ? dy[CB] : dx[CB];

   always_comb begin
      if (steep) begin
         maj0 = req_chan.start_y;  min0 = req_chan.start_x;
         maj1 = req_chan.end_y;    min1 = req_chan.end_x;
      end else begin
         maj0 = req_chan.start_x;  min0 = req_chan.start_y;
         maj1 = req_chan.end_x;    min1 = req_chan.end_y;
      end
   end

   // ---------------- handshake ----------------
   assign step_go        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || step_go;
   assign req_go         = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_go ? 1'b1 : (s1_valid_ff && !step_go);

   // ---------------- step ----------------
   always_comb begin
      if (s1_start_ff) begin
         cur_steep     = s1_steep_ff;
         cur_major     = s1_major_ff;
         cur_minor     = s1_minor_ff;
         cur_major_end = s1_major_end_ff;
         cur_minor_end = s1_minor_end_ff;
         cur_dmaj      = s1_dmaj_ff;
         cur_dmin      = s1_dmin_ff;
         cur_err       = $signed({2'b00, s1_dmaj_ff[CB-1:1]});
         cur_color     = s1_color_ff;
      end else begin
         cur_steep     = steep_ff;
         cur_major     = major_pos_ff;
         cur_minor     = minor_pos_ff;
         cur_major_end = major_end_ff;
         cur_minor_end = minor_end_ff;
         cur_dmaj      = delta_major_ff;
         cur_dmin      = delta_minor_ff;
         cur_err       = error_term_ff;
         cur_color     = held_color_ff;
      end
   end

   assign produce    = s1_start_ff || line_active_ff;
   assign is_last    = (cur_major == cur_major_end);
   assign err_sub    = cur_err - $signed({1'b0, cur_dmin});
   assign minor_step = (cur_minor_end > cur_minor) ? $signed(CB'(1)) : $signed({CB{1'b1}});
   assign minor_in   = err_sub[CB] ? cur_minor + minor_step : cur_minor;
   assign err_in     = err_sub[CB] ? err_sub + $signed({1'b0, cur_dmaj}) : err_sub;
   assign major_in   = cur_major + $signed(CB'(1));

   assign line_active_in = (step_go && produce) ? !is_last : line_active_ff;
   assign out_valid_in   = step_go ? produce : (out_valid_ff && !rsp_chan.ready);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         line_active_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         line_active_ff <= line_active_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_start_ff     <= (req_chan.mode == MODE_START);
         s1_steep_ff     <= steep;
         s1_major_ff     <= swap_ends ? maj1 : maj0;
         s1_minor_ff     <= swap_ends ? min1 : min0;
         s1_major_end_ff <= swap_ends ? maj0 : maj1;
         s1_minor_end_ff <= swap_ends ? min0 : min1;
         s1_dmaj_ff      <= steep ? ady : adx;
         s1_dmin_ff      <= steep ? adx : ady;
         s1_color_ff     <= req_chan.line_color;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && produce) begin
         steep_ff       <= cur_steep;
         major_pos_ff   <= major_in;
         minor_pos_ff   <= minor_in;
         major_end_ff   <= cur_major_end;
         minor_end_ff   <= cur_minor_end;
         delta_major_ff <= cur_dmaj;
         delta_minor_ff <= cur_dmin;
         error_term_ff  <= err_in;
         held_color_ff  <= cur_color;
         pixel_x_ff     <= cur_steep ? cur_minor : cur_major;
         pixel_y_ff     <= cur_steep ? cur_major : cur_minor;
         pixel_color_ff <= cur_color;
         last_pixel_ff  <= is_last;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_x     = pixel_x_ff;
   assign rsp_chan.pixel_y     = pixel_y_ff;
   assign rsp_chan.pixel_color = pixel_color_ff;
   assign rsp_chan.last_pixel  = last_pixel_ff;

endmodule

[design/bres_checker.sv]
// ----------------------------------------------------------------------------
// bres_checker
// Port-level checks for the Bresenham line pixel generator.
// ----------------------------------------------------------------------------
module bres_checker
   import bres_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF)
   (
      input logic                         clock,
      input logic                         reset,
      input logic                         req_valid,
      input logic                         req_ready,
      input logic                         req_mode,
      input logic signed [COORD_BITS-1:0] req_start_x,
      input logic signed [COORD_BITS-1:0] req_start_y,
      input logic signed [COORD_BITS-1:0] req_end_x,
      input logic signed [COORD_BITS-1:0] req_end_y,
      input logic                         rsp_valid,
      input logic                         rsp_ready,
      input logic signed [COORD_BITS-1:0] rsp_pixel_x,
      input logic signed [COORD_BITS-1:0] rsp_pixel_y,
      input logic [COLOR_BITS-1:0]        rsp_pixel_color,
      input logic                         rsp_last_pixel
   );

   logic start_go, point_go, out_free;

   assign start_go = req_valid && req_ready && (req_mode == MODE_START);
   assign point_go = start_go && (req_start_x == req_end_x) && (req_start_y == req_end_y);
   assign out_free = !rsp_valid || rsp_ready;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
      else $error("stalled response changed");

   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      start_go ##1 out_free |=> rsp_valid)
      else $error("start word gave no pixel");

   a_point_line: assert property (@(posedge clock) disable iff (reset)
      point_go ##1 out_free |=> rsp_valid && rsp_last_pixel
         && (rsp_pixel_x == $past(req_start_x, 2)) && (rsp_pixel_y == $past(req_start_y, 2)))
      else $error("single point line wrong");

endmodule

bind bresenham_line_pixel_generator bres_checker #(.COORD_BITS(COORD_BITS)) u_bres_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_mode        (req_chan.mode),
   .req_start_x     (req_chan.start_x),
   .req_start_y     (req_chan.start_y),
   .req_end_x       (req_chan.end_x),
   .req_end_y       (req_chan.end_y),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pixel_x     (rsp_chan.pixel_x),
   .rsp_pixel_y     (rsp_chan.pixel_y),
   .rsp_pixel_color (rsp_chan.pixel_color),
   .rsp_last_pixel  (rsp_chan.last_pixel)
);

[test/bres_line_checker.sv]
// ----------------------------------------------------------------------------
// bres_line_checker
// Watches the request and pixel channels of the Bresenham line generator,
// steps its own copy of the line state on every accepted request word and
// compares each accepted pixel, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module bres_line_checker
   import bres_pkg::*;
   #(parameter int CW = COORD_BITS_DEF)
   (
      input  logic  clock,
      input  logic  reset,
      bres_req_if   req_mon,
      bres_rsp_if   rsp_mon,
      output int    fail_count,
      output int    outstanding,
      output int    pixels_seen,
      output int    lines_seen
   );

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [CW-1:0]   x;
      logic signed [CW-1:0]   y;
      logic [COLOR_BITS-1:0]  color;
      logic                   last;
   } pixel_type;

   pixel_type pending_pixels[$];

   bit                    on_line;
   bit                    steep;
   int                    maj, mnr, maj_stop, mnr_stop, run, rise, err;
   logic [COLOR_BITS-1:0] ink;

   function automatic int mag(int v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic plot_next_pixel();
      pixel_type p;
      p.x     = steep ? mnr[CW-1:0] : maj[CW-1:0];
      p.y     = steep ? maj[CW-1:0] : mnr[CW-1:0];
      p.color = ink;
      p.last  = (maj == maj_stop);
      pending_pixels.push_back(p);
      if (p.last) begin
         on_line = 1'b0;
      end else begin
         err -= rise;
         if (err < 0) begin
            mnr += (mnr_stop > mnr) ? 1 : -1;
            err += run;
         end
         maj++;
      end
   endtask

   task automatic trace_line_word();
      int ax, ay, bx, by, t;
      if (req_mon.mode != MODE_START) begin
         if (on_line)
            plot_next_pixel();
         return;
      end
      ax = req_mon.start_x;
      ay = req_mon.start_y;
      bx = req_mon.end_x;
      by = req_mon.end_y;
      steep = mag(ax - bx) < mag(ay - by);
      if (steep) begin
         t = ax; ax = ay; ay = t;
         t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      maj      = ax;
      mnr      = ay;
      maj_stop = bx;
      mnr_stop = by;
      run      = bx - ax;
      rise     = mag(by - ay);
      err      = run / 2;
      ink      = req_mon.line_color;
      on_line  = 1'b1;
      lines_seen++;
      plot_next_pixel();
   endtask

   function automatic void flag_pixel(bit known, pixel_type want, pixel_type got);
      fail_count++;
      if (fail_count <= 10) begin
         if (known)
            $display({"pixel mismatch at %0t: expected x=%0d y=%0d color=%h last=%b,",
                      " got x=%0d y=%0d color=%h last=%b"},
                     $realtime, want.x, want.y, want.color, want.last,
                     got.x, got.y, got.color, got.last);
         else
            $display("unexpected pixel at %0t: got x=%0d y=%0d color=%h last=%b",
                     $realtime, got.x, got.y, got.color, got.last);
      end
   endfunction

   always @(posedge clock) begin
      pixel_type got, want;
      if (reset) begin
         pending_pixels.delete();
         on_line     = 1'b0;
         steep       = 1'b0;
         outstanding = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            trace_line_word();
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.x     = rsp_mon.pixel_x;
            got.y     = rsp_mon.pixel_y;
            got.color = rsp_mon.pixel_color;
            got.last  = rsp_mon.last_pixel;
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
               flag_pixel(1'b0, '0, got);
            end else begin
               want = pending_pixels.pop_front();
               if (got.x !== want.x || got.y !== want.y ||
                   got.color !== want.color || got.last !== want.last)
                  flag_pixel(1'b1, want, got);
            end
         end
         outstanding = pending_pixels.size();
      end
   end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the Bresenham line generator with directed lines (single points,
// full-range endpoints, steep and reversed lines, idle ticks, abandoned
// lines) and then random lines, mostly short and complete, with random gaps
// and response stalls. The checker beside the block scores every pixel.
// ----------------------------------------------------------------------------
module tb
   import bres_pkg::*;
   ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int   CW        = COORD_BITS_DEF;
   localparam logic MODE_TICK = ~MODE_START;

   logic clock;
   logic reset;
   int   fail_count, outstanding, pixels_seen, lines_seen;
   int   pixels_sent;

   bres_req_if #(.COORD_BITS(CW)) req_chan ();
   bres_rsp_if #(.COORD_BITS(CW)) rsp_chan ();

   bresenham_line_pixel_generator #(.COORD_BITS(CW)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bres_line_checker #(.CW(CW)) line_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .pixels_seen (pixels_seen),
      .lines_seen  (lines_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int rnd_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int clamp(int v);
      return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
   endfunction

   function automatic int mag(int v);
      return (v < 0) ? -v : v;
   endfunction

   // pixel side: phases of steady accept and phases of random stalls
   initial begin
      int  stall, span;
      bit  calm;
      rsp_chan.ready = 1'b0;
      forever begin
         calm = ($urandom_range(3) == 0);
         span = $urandom_range(20, 200);
         while (span > 0) begin
            stall = calm ? 0 : pick_gap();
            repeat (stall) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
               span--;
            end
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
            span--;
         end
      end
   end

   task automatic send_word(logic mode, int sx, int sy, int ex, int ey,
                            logic [COLOR_BITS-1:0] c, int gap);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.start_x    <= sx[CW-1:0];
      req_chan.start_y    <= sy[CW-1:0];
      req_chan.end_x      <= ex[CW-1:0];
      req_chan.end_y      <= ey[CW-1:0];
      req_chan.line_color <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_tick(bit calm);
      send_word(MODE_TICK, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                $urandom, calm ? 0 : pick_gap());
   endtask

   // start word plus a number of ticks; ticks past the far end are idle
   task automatic run_line(int sx, int sy, int ex, int ey,
                           logic [COLOR_BITS-1:0] c, int ticks, bit calm);
      int span;
      span = (mag(ex - sx) > mag(ey - sy)) ? mag(ex - sx) : mag(ey - sy);
      send_word(MODE_START, sx, sy, ex, ey, c, calm ? 0 : pick_gap());
      repeat (ticks) send_tick(calm);
      pixels_sent += 1 + ((ticks < span) ? ticks : span);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int sx, sy, ex, ey, span, ticks, kind, r, lines, guard;
      bit calm;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_START;
      req_chan.start_x    = '0;
      req_chan.start_y    = '0;
      req_chan.end_x      = '0;
      req_chan.end_y      = '0;
      req_chan.line_color = '0;
      pixels_sent         = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      send_word(MODE_TICK, -1, -1, -1, -1, 32'hFFFF_FFFF, 0);
      run_line(0, 0, 0, 0, 32'h0000_0000, 1, 1'b1);
      run_line(2047, -2048, 2047, -2048, 32'hFFFF_FFFF, 0, 1'b0);
      run_line(0, 0, 5, 2, 32'h1234_5678, 5, 1'b0);
      run_line(3, 7, 1, 0, 32'h89AB_CDEF, 7, 1'b1);
      run_line(-2048, -2048, 2047, 2047, 32'hA5A5_5A5A, 2, 1'b0);
      run_line(2047, -2048, -2048, 2047, 32'h5A5A_A5A5, 2, 1'b1);
      run_line(-5, 4, -1, 0, 32'hDEAD_BEEF, 4, 1'b0);
      wait_drained();

      // random lines, mostly short and run to the end
      lines = 0;
      while (pixels_sent < 1500) begin
         kind = $urandom_range(99);
         calm = ($urandom_range(7) == 0);
         sx   = rnd_coord();
         sy   = rnd_coord();
         if (kind < 2) begin
            ex = rnd_coord();
            ey = rnd_coord();
         end else begin
            ex = clamp(sx + int'($urandom_range(40)) - 20);
            ey = clamp(sy + int'($urandom_range(40)) - 20);
         end
         span = (mag(ex - sx) > mag(ey - sy)) ? mag(ex - sx) : mag(ey - sy);
         r = $urandom_range(99);
         if (r < 75)
            ticks = span;
         else if (r < 90)
            ticks = span + $urandom_range(1, 3);
         else
            ticks = $urandom_range(0, span);
         if (kind < 2 && ticks > 50)
            ticks = $urandom_range(50);
         run_line(sx, sy, ex, ey, $urandom, ticks, calm);
         lines++;
         if (lines % 40 == 39)
            wait_drained();
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      guard = 0;
      while (outstanding != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);

      $display("Covered %0d lines and %0d pixels: idle ticks, single points, steep,",
               lines_seen, pixels_seen);
      $display("reversed and full-range lines, lines cut short by a new start.");
      if (outstanding != 0)
         $display("%0d expected pixels never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
design/bres_pkg.sv
design/bres_if.sv
design/bresenham_line_pixel_generator.sv
design/bres_checker.sv
test/bres_line_checker.sv
test/tb.sv
